>>> src/moesi_l1_coherence_controller_assert.svh
// Assertion macros shared by the MOESI L1 controller modules.
`ifndef MOESI_L1_COHERENCE_CONTROLLER_ASSERT_SVH
`define MOESI_L1_COHERENCE_CONTROLLER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define MLC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define MLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mlc_pkg.sv
// Shared constants, codes and item types of the MOESI L1 controller.
package mlc_pkg;

    localparam int LINE_W   = 34;
    localparam int ADDR_W   = 40;
    localparam int LEN_W    = 7;
    localparam int PORT_W   = 8;
    localparam int ARG_W    = 8;
    localparam int CMD_W    = 4;
    localparam int STATUS_W = 3;
    localparam int MTYPE_W  = 4;
    localparam int CHAN_W   = 2;
    localparam int CSTATE_W = 3;
    localparam int MSTATE_W = 4;
    localparam int ACK_W    = 8;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 64;

    localparam int DEF_SET_COUNT        = 64;
    localparam int DEF_WAY_COUNT        = 4;
    localparam int DEF_MISS_ENTRIES     = 8;
    localparam int DEF_LINE_OFFSET_BITS = 6;

    localparam int RES_FIFO_DEPTH = 4;

    // configuration register indexes
    localparam logic CFG_OWN_PORT    = 1'b0;
    localparam logic CFG_UPLINK_PORT = 1'b1;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_STORE      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_RES   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_STORE_COND = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INVALID    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_INV_ACK    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_GETS_FWD   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_GETM_FWD   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_GETM_ACK   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_GETS_RESP  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_GETM_RESP  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_MEM_RESP   = 4'd11;
    localparam logic [CMD_W-1:0] CMD_PUT_ACK    = 4'd12;

    // access status
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COHERENCE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNCOND    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd6;

    // stable line states
    localparam logic [CSTATE_W-1:0] CS_I = 3'd0;
    localparam logic [CSTATE_W-1:0] CS_S = 3'd1;
    localparam logic [CSTATE_W-1:0] CS_E = 3'd2;
    localparam logic [CSTATE_W-1:0] CS_O = 3'd3;
    localparam logic [CSTATE_W-1:0] CS_M = 3'd4;

    // miss entry transient states
    localparam logic [MSTATE_W-1:0] MS_FREE = 4'd0;
    localparam logic [MSTATE_W-1:0] MS_ITOS = 4'd1;
    localparam logic [MSTATE_W-1:0] MS_ITOM = 4'd2;
    localparam logic [MSTATE_W-1:0] MS_STOM = 4'd3;
    localparam logic [MSTATE_W-1:0] MS_OTOM = 4'd4;
    localparam logic [MSTATE_W-1:0] MS_ITOI = 4'd5;
    localparam logic [MSTATE_W-1:0] MS_STOI = 4'd6;
    localparam logic [MSTATE_W-1:0] MS_ETOI = 4'd7;
    localparam logic [MSTATE_W-1:0] MS_MTOI = 4'd8;
    localparam logic [MSTATE_W-1:0] MS_OTOI = 4'd9;

    // outgoing message types
    localparam logic [MTYPE_W-1:0] MT_GETS      = 4'd0;
    localparam logic [MTYPE_W-1:0] MT_GETM      = 4'd1;
    localparam logic [MTYPE_W-1:0] MT_INV_ACK   = 4'd2;
    localparam logic [MTYPE_W-1:0] MT_GETS_RESP = 4'd3;
    localparam logic [MTYPE_W-1:0] MT_GETM_RESP = 4'd4;
    localparam logic [MTYPE_W-1:0] MT_GET_ACK   = 4'd5;
    localparam logic [MTYPE_W-1:0] MT_PUTE      = 4'd6;
    localparam logic [MTYPE_W-1:0] MT_PUTM      = 4'd7;
    localparam logic [MTYPE_W-1:0] MT_PUTS      = 4'd8;
    localparam logic [MTYPE_W-1:0] MT_PUTO      = 4'd9;

    // channels
    localparam logic [CHAN_W-1:0] CH_REQ  = 2'd0;
    localparam logic [CHAN_W-1:0] CH_RESP = 2'd1;
    localparam logic [CHAN_W-1:0] CH_ACK  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] access_address;
        logic [LEN_W-1:0]  access_length;
        logic [LINE_W-1:0] message_line;
        logic [ARG_W-1:0]  message_arg;
    } t_item;

    typedef struct packed {
        logic [MTYPE_W-1:0] send_type;
        logic [CHAN_W-1:0]  send_channel;
        logic [PORT_W-1:0]  send_port;
        logic [LINE_W-1:0]  send_line;
        logic [ARG_W-1:0]   send_arg;
        logic               with_line_data;
    } t_msg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                send_valid;
        t_msg                msg;
        logic                last;
    } t_result;

endpackage

>>> src/mlc_tag_ram.sv
// Per-set row memory holding tags, line states and LRU ranks, with row valid bits.
module mlc_tag_ram #(
    parameter int ROWS   = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 160
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data,
    output logic              o_rd_vld
);

    logic [DATA_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   r_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_vld;

    // write the row array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // mark rows written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // registered read, new data wins on a same-row write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
                r_rd_vld  <= 1'b1;
            end else begin
                r_rd_data <= mem[i_rd_addr];
                r_rd_vld  <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule

>>> src/mlc_engine.sv
// Protocol engine: tag lookup, LRU, miss table and reservation, one item per pass.
`include "moesi_l1_coherence_controller_assert.svh"

module mlc_engine #(
    parameter int SET_COUNT        = mlc_pkg::DEF_SET_COUNT,
    parameter int WAY_COUNT        = mlc_pkg::DEF_WAY_COUNT,
    parameter int MISS_ENTRIES     = mlc_pkg::DEF_MISS_ENTRIES,
    parameter int LINE_OFFSET_BITS = mlc_pkg::DEF_LINE_OFFSET_BITS,
    localparam int SLOG  = $clog2(SET_COUNT),
    localparam int TAG_W = mlc_pkg::LINE_W - SLOG,
    localparam int RK_W  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1,
    localparam int ROW_W = WAY_COUNT * (TAG_W + mlc_pkg::CSTATE_W + RK_W)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_commit,
    input  mlc_pkg::t_item                i_item,
    input  logic [mlc_pkg::PORT_W-1:0]    i_own_port,
    input  logic [mlc_pkg::PORT_W-1:0]    i_uplink_port,
    input  logic [ROW_W-1:0]              i_row,
    input  logic                          i_row_vld,
    output logic [ROW_W-1:0]              o_wr_row,
    output mlc_pkg::t_result              o_res0,
    output mlc_pkg::t_result              o_res1,
    output logic [1:0]                    o_res_cnt
);

    localparam int LW   = mlc_pkg::LINE_W;
    localparam int CW   = mlc_pkg::CSTATE_W;
    localparam int MW   = mlc_pkg::MSTATE_W;
    localparam int AW   = mlc_pkg::ACK_W;
    localparam int WAY_W = RK_W;
    localparam int E_W  = (MISS_ENTRIES > 1) ? $clog2(MISS_ENTRIES) : 1;
    localparam int SOFF = WAY_COUNT * TAG_W;
    localparam int ROFF = WAY_COUNT * (TAG_W + CW);
    localparam logic [RK_W-1:0] TOP_RANK = RK_W'(WAY_COUNT - 1);

    // miss table and reservation
    logic [LW-1:0]                r_ml [MISS_ENTRIES];
    logic [MW-1:0]                r_ms [MISS_ENTRIES];
    logic [AW-1:0]                r_ar [MISS_ENTRIES];
    logic [AW-1:0]                r_an [MISS_ENTRIES];
    logic [MISS_ENTRIES-1:0]      r_ak;
    logic [MISS_ENTRIES-1:0]      r_da;
    logic                         r_rv;
    logic [mlc_pkg::ADDR_W-1:0]   r_ra;

    logic [LW-1:0]                n_ml [MISS_ENTRIES];
    logic [MW-1:0]                n_ms [MISS_ENTRIES];
    logic [AW-1:0]                n_ar [MISS_ENTRIES];
    logic [AW-1:0]                n_an [MISS_ENTRIES];
    logic [MISS_ENTRIES-1:0]      n_ak;
    logic [MISS_ENTRIES-1:0]      n_da;
    logic                         n_rv;
    logic [mlc_pkg::ADDR_W-1:0]   n_ra;

    // row view
    logic [TAG_W-1:0] c_tag [WAY_COUNT];
    logic [CW-1:0]    c_st  [WAY_COUNT];
    logic [RK_W-1:0]  c_rk  [WAY_COUNT];
    logic [TAG_W-1:0] w_tag [WAY_COUNT];
    logic [CW-1:0]    w_st  [WAY_COUNT];
    logic [RK_W-1:0]  w_rk  [WAY_COUNT];

    logic [mlc_pkg::CMD_W-1:0] cmd;
    logic [LW-1:0]    line;
    logic [LW-1:0]    set_part;
    logic [TAG_W-1:0] tag;
    logic [8:0]       end_off;
    logic             crossing;
    logic             hit;
    logic [WAY_W-1:0] hidx;
    logic             fw_ok;
    logic [WAY_W-1:0] fidx;
    logic [WAY_W-1:0] vidx;
    logic             e_hit;
    logic [E_W-1:0]   eidx;
    logic             ef_ok;
    logic [E_W-1:0]   efidx;
    logic [MW-1:0]    s;
    logic             is_load;
    logic             is_store;
    logic             wait_ack;
    logic [MW-1:0]    alloc_st;
    logic             fwd_st;
    logic [mlc_pkg::STATUS_W-1:0] status;
    logic             prim_v;
    mlc_pkg::t_msg    prim;
    logic             put_v;
    mlc_pkg::t_msg    put;
    logic             inst;
    logic [CW-1:0]    inst_st;
    logic [LW-1:0]    old_line;
    logic             touch_en;
    logic [WAY_W-1:0] touch_way;
    logic [RK_W-1:0]  touch_r;
    mlc_pkg::t_result res_none;

    // unpack the row, an unwritten row reads as all invalid with rank zero
    always_comb begin
        for (int w = 0; w < WAY_COUNT; w++) begin
            c_tag[w] = i_row[w*TAG_W +: TAG_W];
            c_st[w]  = i_row_vld ? i_row[SOFF + w*CW +: CW] : mlc_pkg::CS_I;
            c_rk[w]  = i_row_vld ? i_row[ROFF + w*RK_W +: RK_W] : '0;
        end
    end

    // lookups: line, ways and miss entries in parallel
    always_comb begin
        cmd = i_item.command;
        if (cmd <= mlc_pkg::CMD_STORE_COND) begin
            line = LW'(i_item.access_address >> LINE_OFFSET_BITS);
        end else begin
            line = i_item.message_line;
        end
        tag      = TAG_W'(line >> SLOG);
        set_part = line & LW'(SET_COUNT - 1);
        end_off  = 9'(i_item.access_address[LINE_OFFSET_BITS-1:0])
                 + 9'(i_item.access_length) - 9'd1;
        crossing = (i_item.access_length != '0) && ((end_off >> LINE_OFFSET_BITS) != 9'd0);

        hit  = 1'b0;
        hidx = '0;
        fw_ok = 1'b0;
        fidx = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (c_st[w] != mlc_pkg::CS_I && c_tag[w] == tag) begin
                hit  = 1'b1;
                hidx = WAY_W'(w);
            end
            if (c_st[w] == mlc_pkg::CS_I) begin
                fw_ok = 1'b1;
                fidx  = WAY_W'(w);
            end
        end
        // victim: highest rank, lowest way on a tie
        vidx = '0;
        for (int w = 1; w < WAY_COUNT; w++) begin
            if (c_rk[w] > c_rk[vidx]) begin
                vidx = WAY_W'(w);
            end
        end

        e_hit = 1'b0;
        eidx  = '0;
        ef_ok = 1'b0;
        efidx = '0;
        for (int e = MISS_ENTRIES - 1; e >= 0; e--) begin
            if (r_ms[e] != mlc_pkg::MS_FREE && r_ml[e] == line) begin
                e_hit = 1'b1;
                eidx  = E_W'(e);
            end
            if (r_ms[e] == mlc_pkg::MS_FREE) begin
                ef_ok = 1'b1;
                efidx = E_W'(e);
            end
        end
        s = e_hit ? r_ms[eidx] : mlc_pkg::MS_FREE;
    end

    // protocol actions
    always_comb begin
        for (int w = 0; w < WAY_COUNT; w++) begin
            w_tag[w] = c_tag[w];
            w_st[w]  = c_st[w];
            w_rk[w]  = c_rk[w];
        end
        for (int e = 0; e < MISS_ENTRIES; e++) begin
            n_ml[e] = r_ml[e];
            n_ms[e] = r_ms[e];
            n_ar[e] = r_ar[e];
            n_an[e] = r_an[e];
        end
        n_ak = r_ak;
        n_da = r_da;
        n_rv = r_rv;
        n_ra = r_ra;

        status    = mlc_pkg::ST_NONE;
        prim_v    = 1'b0;
        prim      = '0;
        put_v     = 1'b0;
        put       = '0;
        inst      = 1'b0;
        inst_st   = mlc_pkg::CS_M;
        touch_en  = 1'b0;
        touch_way = hidx;
        touch_r   = c_rk[hidx];
        wait_ack  = 1'b0;
        alloc_st  = mlc_pkg::MS_ITOM;
        old_line  = '0;
        fwd_st    = (s == mlc_pkg::MS_STOM) || (s == mlc_pkg::MS_MTOI)
                 || (s == mlc_pkg::MS_STOI) || (s == mlc_pkg::MS_ETOI)
                 || (s == mlc_pkg::MS_OTOM) || (s == mlc_pkg::MS_OTOI);

        is_load  = (cmd == mlc_pkg::CMD_LOAD) || (cmd == mlc_pkg::CMD_LOAD_RES);
        is_store = (cmd == mlc_pkg::CMD_STORE)
                || ((cmd == mlc_pkg::CMD_STORE_COND) && r_rv
                    && (r_ra == i_item.access_address));

        if (is_load) begin
            if (crossing) begin
                status = mlc_pkg::ST_UNALIGNED;
            end else if (hit) begin
                touch_en = 1'b1;
                status   = mlc_pkg::ST_OK;
            end else if (e_hit) begin
                if (s == mlc_pkg::MS_STOM || s == mlc_pkg::MS_OTOM) begin
                    status = mlc_pkg::ST_OK;
                end else if (s == mlc_pkg::MS_ITOM || s == mlc_pkg::MS_ITOS) begin
                    status = mlc_pkg::ST_MISS;
                end else begin
                    status = mlc_pkg::ST_COHERENCE;
                end
            end else if (!ef_ok) begin
                status = mlc_pkg::ST_BUSY;
            end else begin
                n_ml[efidx] = line;
                n_ms[efidx] = mlc_pkg::MS_ITOS;
                n_ar[efidx] = '0;
                n_an[efidx] = '0;
                n_ak[efidx] = 1'b0;
                n_da[efidx] = 1'b0;
                prim_v = 1'b1;
                prim   = '{mlc_pkg::MT_GETS, mlc_pkg::CH_REQ, i_uplink_port, line,
                           i_own_port, 1'b0};
                status = mlc_pkg::ST_MISS;
            end
            // load-reserved sets the reservation on success
            if (cmd == mlc_pkg::CMD_LOAD_RES && status == mlc_pkg::ST_OK) begin
                n_rv = 1'b1;
                n_ra = i_item.access_address;
            end
        end else if (is_store) begin
            if (crossing) begin
                status = mlc_pkg::ST_UNALIGNED;
            end else begin
                touch_en = hit;
                if (hit && (c_st[hidx] == mlc_pkg::CS_E || c_st[hidx] == mlc_pkg::CS_M)) begin
                    w_st[hidx] = mlc_pkg::CS_M;
                    n_rv       = 1'b0;
                    status     = mlc_pkg::ST_OK;
                end else if (e_hit) begin
                    if (s == mlc_pkg::MS_STOM || s == mlc_pkg::MS_OTOM
                        || s == mlc_pkg::MS_ITOM) begin
                        status = mlc_pkg::ST_MISS;
                    end else begin
                        status = mlc_pkg::ST_COHERENCE;
                    end
                end else if (!ef_ok) begin
                    status = mlc_pkg::ST_BUSY;
                end else begin
                    if (hit) begin
                        alloc_st = (c_st[hidx] == mlc_pkg::CS_O) ? mlc_pkg::MS_OTOM
                                                                 : mlc_pkg::MS_STOM;
                        w_st[hidx] = mlc_pkg::CS_I;
                    end
                    n_ml[efidx] = line;
                    n_ms[efidx] = alloc_st;
                    n_ar[efidx] = '0;
                    n_an[efidx] = '0;
                    n_ak[efidx] = 1'b0;
                    n_da[efidx] = 1'b0;
                    prim_v = 1'b1;
                    prim   = '{mlc_pkg::MT_GETM, mlc_pkg::CH_REQ, i_uplink_port, line,
                               i_own_port, 1'b0};
                    status = mlc_pkg::ST_MISS;
                end
            end
        end else if (cmd == mlc_pkg::CMD_STORE_COND) begin
            status = mlc_pkg::ST_UNCOND;
        end else begin
            case (cmd)
                mlc_pkg::CMD_INVALID: begin
                    if (e_hit && (s == mlc_pkg::MS_ITOS || s == mlc_pkg::MS_ETOI
                                  || s == mlc_pkg::MS_ITOI)) begin
                        status = mlc_pkg::ST_COHERENCE;
                    end else begin
                        prim_v = 1'b1;
                        prim   = '{mlc_pkg::MT_INV_ACK, mlc_pkg::CH_ACK,
                                   i_item.message_arg, line, '0, 1'b0};
                        if (hit) begin
                            w_st[hidx] = mlc_pkg::CS_I;
                        end
                        if (e_hit) begin
                            n_ms[eidx] = (s == mlc_pkg::MS_STOI || s == mlc_pkg::MS_MTOI
                                          || s == mlc_pkg::MS_OTOI) ? mlc_pkg::MS_ITOI
                                                                    : mlc_pkg::MS_ITOM;
                        end
                        if (r_rv && line == LW'(r_ra >> LINE_OFFSET_BITS)) begin
                            n_rv = 1'b0;
                        end
                    end
                end
                mlc_pkg::CMD_INV_ACK: begin
                    if (!e_hit) begin
                        status = mlc_pkg::ST_COHERENCE;
                    end else if (s == mlc_pkg::MS_ITOM || s == mlc_pkg::MS_STOM
                                 || s == mlc_pkg::MS_OTOM) begin
                        wait_ack = !r_ak[eidx] || (r_an[eidx] != r_ar[eidx] + AW'(1))
                                || (s == mlc_pkg::MS_ITOM && !r_da[eidx]);
                        if (wait_ack) begin
                            n_ar[eidx] = r_ar[eidx] + AW'(1);
                        end else begin
                            prim_v  = 1'b1;
                            prim    = '{mlc_pkg::MT_GET_ACK, mlc_pkg::CH_ACK, i_uplink_port,
                                        line, i_own_port, 1'b0};
                            inst    = 1'b1;
                            inst_st = mlc_pkg::CS_M;
                        end
                    end
                end
                mlc_pkg::CMD_GETS_FWD, mlc_pkg::CMD_GETM_FWD: begin
                    if (hit == (e_hit && fwd_st)) begin
                        status = mlc_pkg::ST_COHERENCE;
                    end else if (cmd == mlc_pkg::CMD_GETS_FWD) begin
                        prim_v = 1'b1;
                        prim   = '{mlc_pkg::MT_GETS_RESP, mlc_pkg::CH_RESP,
                                   i_item.message_arg, line, 8'd1, 1'b1};
                        if (hit) begin
                            w_st[hidx] = mlc_pkg::CS_O;
                        end else if (s == mlc_pkg::MS_MTOI || s == mlc_pkg::MS_ETOI
                                     || s == mlc_pkg::MS_STOI) begin
                            n_ms[eidx] = mlc_pkg::MS_OTOI;
                        end
                    end else begin
                        prim_v = 1'b1;
                        prim   = '{mlc_pkg::MT_GETM_RESP, mlc_pkg::CH_RESP,
                                   i_item.message_arg, line, 8'd0, 1'b1};
                        if (hit) begin
                            w_st[hidx] = mlc_pkg::CS_I;
                        end else begin
                            n_ms[eidx] = (s == mlc_pkg::MS_STOM || s == mlc_pkg::MS_OTOM)
                                       ? mlc_pkg::MS_ITOM : mlc_pkg::MS_ITOI;
                        end
                    end
                end
                mlc_pkg::CMD_GETM_ACK: begin
                    if (!e_hit) begin
                        status = mlc_pkg::ST_COHERENCE;
                    end else if (s == mlc_pkg::MS_ITOM || s == mlc_pkg::MS_STOM
                                 || s == mlc_pkg::MS_OTOM) begin
                        wait_ack = (i_item.message_arg != r_ar[eidx])
                                || (s == mlc_pkg::MS_ITOM && !r_da[eidx]);
                        if (wait_ack) begin
                            n_ak[eidx] = 1'b1;
                            n_an[eidx] = i_item.message_arg;
                        end else begin
                            prim_v  = 1'b1;
                            prim    = '{mlc_pkg::MT_GET_ACK, mlc_pkg::CH_ACK, i_uplink_port,
                                        line, i_own_port, 1'b0};
                            inst    = 1'b1;
                            inst_st = mlc_pkg::CS_M;
                        end
                    end
                end
                mlc_pkg::CMD_GETS_RESP: begin
                    if (!e_hit || s != mlc_pkg::MS_ITOS) begin
                        status = mlc_pkg::ST_COHERENCE;
                    end else begin
                        prim_v  = (i_item.message_arg != '0);
                        prim    = '{mlc_pkg::MT_GET_ACK, mlc_pkg::CH_ACK, i_uplink_port,
                                    line, i_own_port, 1'b0};
                        inst    = 1'b1;
                        inst_st = prim_v ? mlc_pkg::CS_S : mlc_pkg::CS_E;
                    end
                end
                mlc_pkg::CMD_GETM_RESP: begin
                    if (!e_hit || s != mlc_pkg::MS_ITOM) begin
                        status = mlc_pkg::ST_COHERENCE;
                    end else if (i_item.message_arg == '0
                                 && (!r_ak[eidx] || r_an[eidx] != r_ar[eidx])) begin
                        n_da[eidx] = 1'b1;
                    end else begin
                        prim_v  = (i_item.message_arg == '0);
                        prim    = '{mlc_pkg::MT_GET_ACK, mlc_pkg::CH_ACK, i_uplink_port,
                                    line, i_own_port, 1'b0};
                        inst    = 1'b1;
                        inst_st = mlc_pkg::CS_M;
                    end
                end
                mlc_pkg::CMD_MEM_RESP: begin
                    if (!e_hit || (s != mlc_pkg::MS_ITOM && s != mlc_pkg::MS_ITOS)) begin
                        status = mlc_pkg::ST_COHERENCE;
                    end else begin
                        prim_v  = 1'b1;
                        prim    = '{mlc_pkg::MT_GET_ACK, mlc_pkg::CH_ACK, i_uplink_port,
                                    line, i_own_port, 1'b0};
                        inst    = 1'b1;
                        inst_st = (s == mlc_pkg::MS_ITOM) ? mlc_pkg::CS_M : mlc_pkg::CS_E;
                    end
                end
                mlc_pkg::CMD_PUT_ACK: begin
                    if (!e_hit || !(s == mlc_pkg::MS_ITOI || s == mlc_pkg::MS_MTOI
                                    || s == mlc_pkg::MS_STOI || s == mlc_pkg::MS_ETOI
                                    || s == mlc_pkg::MS_OTOI)) begin
                        status = mlc_pkg::ST_COHERENCE;
                    end else begin
                        n_ms[eidx] = mlc_pkg::MS_FREE;
                    end
                end
                default: begin
                    status = mlc_pkg::ST_NONE;
                end
            endcase
        end

        // fill the line: in place, into a free way, or over the LRU victim
        if (inst) begin
            touch_en = 1'b1;
            if (hit) begin
                w_st[hidx] = inst_st;
                n_ms[eidx] = mlc_pkg::MS_FREE;
            end else if (fw_ok) begin
                w_tag[fidx] = tag;
                w_st[fidx]  = inst_st;
                touch_way   = fidx;
                touch_r     = TOP_RANK;
                n_ms[eidx]  = mlc_pkg::MS_FREE;
            end else begin
                old_line    = (LW'(c_tag[vidx]) << SLOG) | set_part;
                w_tag[vidx] = tag;
                w_st[vidx]  = inst_st;
                touch_way   = vidx;
                touch_r     = c_rk[vidx];
                n_ml[eidx]  = old_line;
                n_ar[eidx]  = '0;
                n_an[eidx]  = '0;
                n_ak[eidx]  = 1'b0;
                n_da[eidx]  = 1'b0;
                put_v = 1'b1;
                if (c_st[vidx] == mlc_pkg::CS_E) begin
                    n_ms[eidx] = mlc_pkg::MS_ETOI;
                    put = '{mlc_pkg::MT_PUTE, mlc_pkg::CH_REQ, i_uplink_port, old_line,
                            i_own_port, 1'b0};
                end else if (c_st[vidx] == mlc_pkg::CS_M) begin
                    n_ms[eidx] = mlc_pkg::MS_MTOI;
                    put = '{mlc_pkg::MT_PUTM, mlc_pkg::CH_REQ, i_uplink_port, old_line,
                            i_own_port, 1'b1};
                end else if (c_st[vidx] == mlc_pkg::CS_O) begin
                    n_ms[eidx] = mlc_pkg::MS_OTOI;
                    put = '{mlc_pkg::MT_PUTO, mlc_pkg::CH_REQ, i_uplink_port, old_line,
                            i_own_port, 1'b1};
                end else begin
                    n_ms[eidx] = mlc_pkg::MS_STOI;
                    put = '{mlc_pkg::MT_PUTS, mlc_pkg::CH_REQ, i_uplink_port, old_line,
                            i_own_port, 1'b0};
                end
            end
        end

        // age the set around the touched way
        if (touch_en) begin
            for (int w = 0; w < WAY_COUNT; w++) begin
                if (WAY_W'(w) == touch_way) begin
                    w_rk[w] = '0;
                end else if (c_rk[w] < touch_r && c_rk[w] < TOP_RANK) begin
                    w_rk[w] = c_rk[w] + RK_W'(1);
                end
            end
        end
    end

    // pack the row for write-back
    always_comb begin
        o_wr_row = '0;
        for (int w = 0; w < WAY_COUNT; w++) begin
            o_wr_row[w*TAG_W +: TAG_W]       = w_tag[w];
            o_wr_row[SOFF + w*CW +: CW]      = w_st[w];
            o_wr_row[ROFF + w*RK_W +: RK_W]  = w_rk[w];
        end
    end

    // form result items, the fill's eviction message follows the primary one
    always_comb begin
        res_none = '{status, 1'b0, '0, 1'b1};
        o_res0   = res_none;
        o_res1   = res_none;
        o_res_cnt = 2'd1;
        if (prim_v && put_v) begin
            o_res0    = '{status, 1'b1, prim, 1'b0};
            o_res1    = '{status, 1'b1, put, 1'b1};
            o_res_cnt = 2'd2;
        end else if (prim_v) begin
            o_res0 = '{status, 1'b1, prim, 1'b1};
        end else if (put_v) begin
            o_res0 = '{status, 1'b1, put, 1'b1};
        end
    end

    // miss entry payload
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            for (int e = 0; e < MISS_ENTRIES; e++) begin
                r_ml[e] <= n_ml[e];
            end
            r_ra <= n_ra;
        end
    end

    // miss entry control and reservation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MISS_ENTRIES; e++) begin
                r_ms[e] <= mlc_pkg::MS_FREE;
                r_ar[e] <= '0;
                r_an[e] <= '0;
            end
            r_ak <= '0;
            r_da <= '0;
            r_rv <= 1'b0;
        end else if (i_commit) begin
            for (int e = 0; e < MISS_ENTRIES; e++) begin
                r_ms[e] <= n_ms[e];
                r_ar[e] <= n_ar[e];
                r_an[e] <= n_an[e];
            end
            r_ak <= n_ak;
            r_da <= n_da;
            r_rv <= n_rv;
        end
    end

    `MLC_ASSERT(a_two_msgs, i_commit && (o_res_cnt == 2'd2), o_res0.send_valid && o_res1.send_valid && !o_res0.last, "two results without two messages")
    `MLC_ASSERT(a_evict_fill, put_v, inst && !hit && !fw_ok, "eviction outside a fill of a full set")

endmodule

>>> src/mlc_res_fifo.sv
// Result queue: takes up to two result items per cycle, hands out one per cycle while the reader is ready.
`include "moesi_l1_coherence_controller_assert.svh"

module mlc_res_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  mlc_pkg::t_result i_d0,
    input  mlc_pkg::t_result i_d1,
    output logic             o_space,
    output logic             o_valid,
    output mlc_pkg::t_result o_data,
    input  logic             i_ready
);

    localparam int DEPTH = mlc_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    mlc_pkg::t_result  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              pop;

    assign pop     = (r_cnt != '0) && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_space = (r_cnt <= CNT_W'(DEPTH - 2));

    // store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= i_d1;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PTR_W'(i_push_cnt);
            r_rp  <= r_rp + PTR_W'(pop);
            r_cnt <= r_cnt + CNT_W'(i_push_cnt) - CNT_W'(pop);
        end
    end

    `MLC_ASSERT(a_fifo_bound, 1'b1, r_cnt <= CNT_W'(DEPTH), "result queue count out of range")
    `MLC_ASSERT(a_fifo_room, i_push_cnt != 2'd0, o_space, "push into a full result queue")

endmodule

>>> src/moesi_l1_coherence_controller.sv
// Top level of the MOESI L1 coherence controller: stream ports, input stage, config.
//
// The controller takes one item per cycle while the result queue has room: a core
// access or a coherence message. An accepted item reads its set's row (tags, states,
// LRU ranks) from the row memory in the accept cycle; in the next cycle the protocol
// engine resolves it against the row, the miss table and the reservation, and once the
// result queue has room it writes the row back and queues its one or two result items.
// Input is taken every cycle as long as the four-entry result queue has room for two
// items; an item that sends both a request and an eviction puts two result items on
// the output, so sustained throughput is one item per cycle only for single-result
// items on an unstalled output. SET_COUNT must be a power of two. Configuration is taken
// on any cycle with i_cfg_we high and is meant to be written while the block is idle.
`include "moesi_l1_coherence_controller_assert.svh"

module moesi_l1_coherence_controller #(
    parameter int SET_COUNT        = mlc_pkg::DEF_SET_COUNT,
    parameter int WAY_COUNT        = mlc_pkg::DEF_WAY_COUNT,
    parameter int MISS_ENTRIES     = mlc_pkg::DEF_MISS_ENTRIES,
    parameter int LINE_OFFSET_BITS = mlc_pkg::DEF_LINE_OFFSET_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command, access_address, access_length, message_line, message_arg
    input  logic [mlc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // status, send_valid, send_type, send_channel, send_port, send_line, send_arg,
    // with_line_data
    output logic [mlc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [mlc_pkg::PORT_W-1:0]        i_cfg_data
);

    localparam int LW    = mlc_pkg::LINE_W;
    localparam int SLOG  = $clog2(SET_COUNT);
    localparam int SET_W = (SLOG > 0) ? SLOG : 1;
    localparam int TAG_W = LW - SLOG;
    localparam int RK_W  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int ROW_W = WAY_COUNT * (TAG_W + mlc_pkg::CSTATE_W + RK_W);

    logic                        r_a_valid;
    mlc_pkg::t_item              r_item;
    mlc_pkg::t_item              in_item;
    logic [mlc_pkg::PORT_W-1:0]  r_own_port;
    logic [mlc_pkg::PORT_W-1:0]  r_uplink_port;
    logic                        w_accept;
    logic                        w_commit;
    logic                        w_space;
    logic [SET_W-1:0]            in_set;
    logic [SET_W-1:0]            cur_set;
    logic [ROW_W-1:0]            rd_row;
    logic                        rd_vld;
    logic [ROW_W-1:0]            wr_row;
    mlc_pkg::t_result            res0;
    mlc_pkg::t_result            res1;
    mlc_pkg::t_result            out_res;
    logic [1:0]                  res_cnt;

    function automatic logic [SET_W-1:0] set_of(input mlc_pkg::t_item it);
        logic [LW-1:0] ln;
        if (it.command <= mlc_pkg::CMD_STORE_COND) begin
            ln = LW'(it.access_address >> LINE_OFFSET_BITS);
        end else begin
            ln = it.message_line;
        end
        return SET_W'(ln & LW'(SET_COUNT - 1));
    endfunction

    // unpack the input item
    always_comb begin
        in_item.command        = s_axis_tdata[3:0];
        in_item.access_address = s_axis_tdata[43:4];
        in_item.access_length  = s_axis_tdata[50:44];
        in_item.message_line   = s_axis_tdata[84:51];
        in_item.message_arg    = s_axis_tdata[92:85];
        in_set  = set_of(in_item);
        cur_set = set_of(r_item);
    end

    assign w_commit      = r_a_valid && w_space;
    assign s_axis_tready = !r_a_valid || w_space;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // hold the item while its row is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= in_item;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_port    <= '0;
            r_uplink_port <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == mlc_pkg::CFG_OWN_PORT) begin
                r_own_port <= i_cfg_data;
            end else begin
                r_uplink_port <= i_cfg_data;
            end
        end
    end

    mlc_tag_ram #(
        .ROWS   (SET_COUNT),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (in_set),
        .i_wr_en   (w_commit),
        .i_wr_addr (cur_set),
        .i_wr_data (wr_row),
        .o_rd_data (rd_row),
        .o_rd_vld  (rd_vld)
    );

    mlc_engine #(
        .SET_COUNT        (SET_COUNT),
        .WAY_COUNT        (WAY_COUNT),
        .MISS_ENTRIES     (MISS_ENTRIES),
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_commit      (w_commit),
        .i_item        (r_item),
        .i_own_port    (r_own_port),
        .i_uplink_port (r_uplink_port),
        .i_row         (rd_row),
        .i_row_vld     (rd_vld),
        .o_wr_row      (wr_row),
        .o_res0        (res0),
        .o_res1        (res1),
        .o_res_cnt     (res_cnt)
    );

    mlc_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_commit ? res_cnt : 2'd0),
        .i_d0       (res0),
        .i_d1       (res1),
        .o_space    (w_space),
        .o_valid    (m_axis_tvalid),
        .o_data     (out_res),
        .i_ready    (m_axis_tready)
    );

    // pack the result item
    assign m_axis_tdata = {3'b000, out_res.msg.with_line_data, out_res.msg.send_arg,
                           out_res.msg.send_line, out_res.msg.send_port,
                           out_res.msg.send_channel, out_res.msg.send_type,
                           out_res.send_valid, out_res.status};
    assign m_axis_tlast = out_res.last;

    `MLC_ASSERT_NXT(a_commit_out, w_commit, m_axis_tvalid, "committed item left no result")
    `MLC_ASSERT(a_no_lost_item, r_a_valid && !w_space, !s_axis_tready, "input taken over a stalled item")

endmodule

>>> verif/mlc_checker.sv
// Checker for the MOESI L1 controller: watches both streams, predicts results and compares.
`timescale 1ns / 100ps

module mlc_checker
    import mlc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,
    input  logic                   i_out_tlast,
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [PORT_W-1:0]      i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_results_seen
);

    localparam int SETS  = DEF_SET_COUNT;
    localparam int WAYS  = DEF_WAY_COUNT;
    localparam int MISSN = DEF_MISS_ENTRIES;
    localparam int OFFB  = DEF_LINE_OFFSET_BITS;
    localparam int SETB  = $clog2(SETS);

    // predictor state
    logic [LINE_W-SETB-1:0] tag_q [SETS*WAYS];
    logic [CSTATE_W-1:0]    cst_q [SETS*WAYS];
    int                     rank_q[SETS*WAYS];
    logic [LINE_W-1:0]      mline_q[MISSN];
    logic [MSTATE_W-1:0]    mst_q  [MISSN];
    logic [ACK_W-1:0]       acks_got[MISSN];
    logic [ACK_W-1:0]       acks_need[MISSN];
    bit                     cnt_known[MISSN];
    bit                     data_in[MISSN];
    bit                     resv_ok;
    logic [ADDR_W-1:0]      resv_addr;
    logic [PORT_W-1:0]      own_port;
    logic [PORT_W-1:0]      uplink_port;

    // messages produced by the item being predicted
    t_msg  msg_buf[2];
    int    n_msg;

    t_result expected_q[$];
    int      mismatches;

    assign o_pending   = expected_q.size();
    assign o_fail_count = mismatches;

    function automatic void queue_msg(logic [MTYPE_W-1:0] ty, logic [CHAN_W-1:0] ch,
                                      logic [PORT_W-1:0] port, logic [LINE_W-1:0] line,
                                      logic [ARG_W-1:0] arg, logic dat);
        if (n_msg >= 2) return;
        msg_buf[n_msg] = '{ty, ch, port, line, arg, dat};
        n_msg++;
    endfunction

    function automatic int find_way(logic [LINE_W-1:0] line);
        int base;
        base = int'(line[SETB-1:0]) * WAYS;
        for (int w = 0; w < WAYS; w++)
            if (cst_q[base+w] != CS_I && tag_q[base+w] == line[LINE_W-1:SETB]) return base + w;
        return -1;
    endfunction

    function automatic void lru_touch(int idx);
        int base;
        int r;
        base = idx - idx % WAYS;
        r = rank_q[idx];
        for (int w = 0; w < WAYS; w++)
            if (base + w != idx && rank_q[base+w] < r && rank_q[base+w] < WAYS - 1)
                rank_q[base+w]++;
        rank_q[idx] = 0;
    endfunction

    function automatic int find_miss(logic [LINE_W-1:0] line);
        for (int e = 0; e < MISSN; e++)
            if (mst_q[e] != MS_FREE && mline_q[e] == line) return e;
        return -1;
    endfunction

    function automatic void claim_entry(int e, logic [LINE_W-1:0] line, logic [MSTATE_W-1:0] st);
        mline_q[e]   = line;
        mst_q[e]     = st;
        acks_got[e]  = '0;
        acks_need[e] = '0;
        cnt_known[e] = 0;
        data_in[e]   = 0;
    endfunction

    function automatic int alloc_miss(logic [LINE_W-1:0] line, logic [MSTATE_W-1:0] st);
        for (int e = 0; e < MISSN; e++)
            if (mst_q[e] == MS_FREE) begin
                claim_entry(e, line, st);
                return e;
            end
        return -1;
    endfunction

    // Fill a line from miss entry e; a full set evicts its LRU way into entry e.
    function automatic void fill_line(logic [LINE_W-1:0] line, int e, logic [CSTATE_W-1:0] st);
        int base;
        int idx;
        logic [LINE_W-1:0]   old_line;
        logic [CSTATE_W-1:0] old_st;
        base = int'(line[SETB-1:0]) * WAYS;
        idx = find_way(line);
        if (idx >= 0) begin
            cst_q[idx] = st;
            lru_touch(idx);
            mst_q[e] = MS_FREE;
            return;
        end
        for (int w = 0; w < WAYS; w++)
            if (cst_q[base+w] == CS_I) begin
                tag_q[base+w]  = line[LINE_W-1:SETB];
                cst_q[base+w]  = st;
                rank_q[base+w] = WAYS - 1;
                lru_touch(base + w);
                mst_q[e] = MS_FREE;
                return;
            end
        idx = base;
        for (int w = 1; w < WAYS; w++)
            if (rank_q[base+w] > rank_q[idx]) idx = base + w;
        old_line = {tag_q[idx], line[SETB-1:0]};
        old_st = cst_q[idx];
        tag_q[idx] = line[LINE_W-1:SETB];
        cst_q[idx] = st;
        lru_touch(idx);
        case (old_st)
            CS_E: begin
                claim_entry(e, old_line, MS_ETOI);
                queue_msg(MT_PUTE, CH_REQ, uplink_port, old_line, own_port, 1'b0);
            end
            CS_M: begin
                claim_entry(e, old_line, MS_MTOI);
                queue_msg(MT_PUTM, CH_REQ, uplink_port, old_line, own_port, 1'b1);
            end
            CS_O: begin
                claim_entry(e, old_line, MS_OTOI);
                queue_msg(MT_PUTO, CH_REQ, uplink_port, old_line, own_port, 1'b1);
            end
            default: begin
                claim_entry(e, old_line, MS_STOI);
                queue_msg(MT_PUTS, CH_REQ, uplink_port, old_line, own_port, 1'b0);
            end
        endcase
    endfunction

    function automatic void finish_getm(logic [LINE_W-1:0] line, int e);
        queue_msg(MT_GET_ACK, CH_ACK, uplink_port, line, own_port, 1'b0);
        fill_line(line, e, CS_M);
    endfunction

    function automatic bit crosses_line(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
        logic [ADDR_W+1:0] end_addr;
        end_addr = {2'b0, addr} + len - 1;
        return len != 0 && ({2'b0, addr} >> OFFB) != (end_addr >> OFFB);
    endfunction

    function automatic logic [STATUS_W-1:0] core_load(logic [ADDR_W-1:0] addr,
                                                      logic [LEN_W-1:0] len);
        logic [LINE_W-1:0] line;
        int idx;
        int e;
        if (crosses_line(addr, len)) return ST_UNALIGNED;
        line = addr[OFFB +: LINE_W];
        idx = find_way(line);
        if (idx >= 0) begin
            lru_touch(idx);
            return ST_OK;
        end
        e = find_miss(line);
        if (e >= 0) begin
            if (mst_q[e] == MS_STOM || mst_q[e] == MS_OTOM) return ST_OK;
            if (mst_q[e] == MS_ITOM || mst_q[e] == MS_ITOS) return ST_MISS;
            return ST_COHERENCE;
        end
        if (alloc_miss(line, MS_ITOS) < 0) return ST_BUSY;
        queue_msg(MT_GETS, CH_REQ, uplink_port, line, own_port, 1'b0);
        return ST_MISS;
    endfunction

    function automatic logic [STATUS_W-1:0] core_store(logic [ADDR_W-1:0] addr,
                                                       logic [LEN_W-1:0] len);
        logic [LINE_W-1:0]   line;
        logic [MSTATE_W-1:0] ns;
        int idx;
        int e;
        if (crosses_line(addr, len)) return ST_UNALIGNED;
        line = addr[OFFB +: LINE_W];
        idx = find_way(line);
        if (idx >= 0) begin
            lru_touch(idx);
            if (cst_q[idx] == CS_E || cst_q[idx] == CS_M) begin
                cst_q[idx] = CS_M;
                resv_ok = 0;
                return ST_OK;
            end
        end
        e = find_miss(line);
        if (e >= 0) begin
            if (mst_q[e] == MS_STOM || mst_q[e] == MS_OTOM || mst_q[e] == MS_ITOM) return ST_MISS;
            return ST_COHERENCE;
        end
        ns = MS_ITOM;
        if (idx >= 0) ns = (cst_q[idx] == CS_O) ? MS_OTOM : MS_STOM;
        if (alloc_miss(line, ns) < 0) return ST_BUSY;
        queue_msg(MT_GETM, CH_REQ, uplink_port, line, own_port, 1'b0);
        if (idx >= 0) cst_q[idx] = CS_I;
        return ST_MISS;
    endfunction

    function automatic bit forwardable(logic [MSTATE_W-1:0] s);
        return s == MS_STOM || s == MS_MTOI || s == MS_STOI || s == MS_ETOI
            || s == MS_OTOM || s == MS_OTOI;
    endfunction

    function automatic bit getm_pending(logic [MSTATE_W-1:0] s);
        return s == MS_ITOM || s == MS_STOM || s == MS_OTOM;
    endfunction

    function automatic logic [STATUS_W-1:0] bus_message(logic [CMD_W-1:0] cmd,
                                                        logic [LINE_W-1:0] line,
                                                        logic [ARG_W-1:0] arg);
        int e;
        int idx;
        logic [MSTATE_W-1:0] s;
        bit hold;
        bit in_miss;
        e = find_miss(line);
        s = (e >= 0) ? mst_q[e] : MS_FREE;
        idx = find_way(line);
        case (cmd)
            CMD_INVALID: begin
                if (e >= 0 && (s == MS_ITOS || s == MS_ETOI || s == MS_ITOI)) return ST_COHERENCE;
                queue_msg(MT_INV_ACK, CH_ACK, arg, line, '0, 1'b0);
                if (idx >= 0) cst_q[idx] = CS_I;
                if (e >= 0)
                    mst_q[e] = (s == MS_STOI || s == MS_MTOI || s == MS_OTOI) ? MS_ITOI : MS_ITOM;
                if (resv_ok && line == resv_addr[OFFB +: LINE_W]) resv_ok = 0;
            end
            CMD_INV_ACK: begin
                if (e < 0) return ST_COHERENCE;
                if (getm_pending(s)) begin
                    hold = !cnt_known[e] || acks_need[e] != ACK_W'(acks_got[e] + 1);
                    if (s == MS_ITOM && !data_in[e]) hold = 1;
                    if (hold) acks_got[e] = acks_got[e] + 1;
                    else finish_getm(line, e);
                end
            end
            CMD_GETS_FWD, CMD_GETM_FWD: begin
                in_miss = e >= 0 && forwardable(s);
                if ((idx >= 0) == in_miss) return ST_COHERENCE;
                if (cmd == CMD_GETS_FWD) begin
                    queue_msg(MT_GETS_RESP, CH_RESP, arg, line, 8'd1, 1'b1);
                    if (idx >= 0) cst_q[idx] = CS_O;
                    else if (s == MS_MTOI || s == MS_ETOI || s == MS_STOI) mst_q[e] = MS_OTOI;
                end else begin
                    queue_msg(MT_GETM_RESP, CH_RESP, arg, line, 8'd0, 1'b1);
                    if (idx >= 0) cst_q[idx] = CS_I;
                    else mst_q[e] = (s == MS_STOM || s == MS_OTOM) ? MS_ITOM : MS_ITOI;
                end
            end
            CMD_GETM_ACK: begin
                if (e < 0) return ST_COHERENCE;
                if (getm_pending(s)) begin
                    hold = arg != acks_got[e];
                    if (s == MS_ITOM && !data_in[e]) hold = 1;
                    if (hold) begin
                        cnt_known[e] = 1;
                        acks_need[e] = arg;
                    end else begin
                        finish_getm(line, e);
                    end
                end
            end
            CMD_GETS_RESP: begin
                if (e < 0 || s != MS_ITOS) return ST_COHERENCE;
                if (arg > 0) queue_msg(MT_GET_ACK, CH_ACK, uplink_port, line, own_port, 1'b0);
                fill_line(line, e, (arg > 0) ? CS_S : CS_E);
            end
            CMD_GETM_RESP: begin
                if (e < 0 || s != MS_ITOM) return ST_COHERENCE;
                if (arg == 0 && (!cnt_known[e] || acks_need[e] != acks_got[e])) begin
                    data_in[e] = 1;
                end else begin
                    if (arg == 0) queue_msg(MT_GET_ACK, CH_ACK, uplink_port, line, own_port, 1'b0);
                    fill_line(line, e, CS_M);
                end
            end
            CMD_MEM_RESP: begin
                if (e < 0 || (s != MS_ITOM && s != MS_ITOS)) return ST_COHERENCE;
                queue_msg(MT_GET_ACK, CH_ACK, uplink_port, line, own_port, 1'b0);
                fill_line(line, e, (s == MS_ITOM) ? CS_M : CS_E);
            end
            CMD_PUT_ACK: begin
                if (e < 0 || !(s == MS_ITOI || s == MS_MTOI || s == MS_STOI || s == MS_ETOI
                               || s == MS_OTOI))
                    return ST_COHERENCE;
                mst_q[e] = MS_FREE;
            end
            default: ;
        endcase
        return ST_NONE;
    endfunction

    // Work out the results of one accepted item and queue them.
    function automatic void predict_item(t_item it);
        logic [STATUS_W-1:0] st;
        t_result r;
        int n;
        n_msg = 0;
        case (it.command)
            CMD_LOAD:  st = core_load(it.access_address, it.access_length);
            CMD_STORE: st = core_store(it.access_address, it.access_length);
            CMD_LOAD_RES: begin
                st = core_load(it.access_address, it.access_length);
                if (st == ST_OK) begin
                    resv_ok = 1;
                    resv_addr = it.access_address;
                end
            end
            CMD_STORE_COND:
                st = (resv_ok && resv_addr == it.access_address)
                   ? core_store(it.access_address, it.access_length) : ST_UNCOND;
            default: st = bus_message(it.command, it.message_line, it.message_arg);
        endcase
        n = (n_msg != 0) ? n_msg : 1;
        for (int k = 0; k < n; k++) begin
            r = '0;
            r.status = st;
            if (k < n_msg) begin
                r.send_valid = 1'b1;
                r.msg = msg_buf[k];
            end
            r.last = (k == n - 1);
            expected_q.push_back(r);
        end
    endfunction

    function automatic void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
        if (mismatches < 10)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, exp_v, act_v);
        mismatches++;
    endfunction

    // Track config, inputs and results at each rising edge.
    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < SETS*WAYS; i++) begin
                tag_q[i] = '0;
                cst_q[i] = CS_I;
                rank_q[i] = 0;
            end
            for (int e = 0; e < MISSN; e++) claim_entry(e, '0, MS_FREE);
            resv_ok = 0;
            resv_addr = '0;
            own_port = '0;
            uplink_port = '0;
            expected_q.delete();
            mismatches = 0;
            o_results_seen = 0;
        end else begin
            // compare an accepted result against the oldest expectation
            if (i_out_tvalid && i_out_tready) begin
                got.status         = i_out_tdata[2:0];
                got.send_valid     = i_out_tdata[3];
                got.msg.send_type  = i_out_tdata[7:4];
                got.msg.send_channel = i_out_tdata[9:8];
                got.msg.send_port  = i_out_tdata[17:10];
                got.msg.send_line  = i_out_tdata[51:18];
                got.msg.send_arg   = i_out_tdata[59:52];
                got.msg.with_line_data = i_out_tdata[60];
                got.last           = i_out_tlast;
                o_results_seen++;
                if (expected_q.size() == 0) begin
                    report("unexpected item", '0, i_out_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status != want.status) report("status", want.status, got.status);
                    if (got.send_valid != want.send_valid)
                        report("send_valid", want.send_valid, got.send_valid);
                    if (got.msg.send_type != want.msg.send_type)
                        report("send_type", want.msg.send_type, got.msg.send_type);
                    if (got.msg.send_channel != want.msg.send_channel)
                        report("send_channel", want.msg.send_channel, got.msg.send_channel);
                    if (got.msg.send_port != want.msg.send_port)
                        report("send_port", want.msg.send_port, got.msg.send_port);
                    if (got.msg.send_line != want.msg.send_line)
                        report("send_line", want.msg.send_line, got.msg.send_line);
                    if (got.msg.send_arg != want.msg.send_arg)
                        report("send_arg", want.msg.send_arg, got.msg.send_arg);
                    if (got.msg.with_line_data != want.msg.with_line_data)
                        report("with_line_data", want.msg.with_line_data,
                               got.msg.with_line_data);
                    if (got.last != want.last) report("last", want.last, got.last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OWN_PORT) own_port = i_cfg_data;
                else uplink_port = i_cfg_data;
            end
            if (i_in_tvalid && i_in_tready) begin
                it.command        = i_in_tdata[3:0];
                it.access_address = i_in_tdata[43:4];
                it.access_length  = i_in_tdata[50:44];
                it.message_line   = i_in_tdata[84:51];
                it.message_arg    = i_in_tdata[92:85];
                predict_item(it);
            end
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the MOESI L1 controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import mlc_pkg::*;

    localparam int PHASE_ITEMS = 350;
    localparam int WATCH_LIMIT = 4000;
    localparam int LONG_HOLD   = 200;
    localparam int POOL_N      = 12;

    logic                   i_clk;
    logic                   i_rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   i_cfg_we;
    logic                   i_cfg_idx;
    logic [PORT_W-1:0]      i_cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_asked;
    int hold_given;
    int hold_left;
    int quiet_cycles;
    logic [LINE_W-1:0] line_pool[POOL_N];
    logic [ADDR_W-1:0] last_lr_addr;

    moesi_l1_coherence_controller u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    mlc_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_tdata(s_axis_tdata), .i_in_tvalid(s_axis_tvalid), .i_in_tready(s_axis_tready),
        .i_out_tdata(m_axis_tdata), .i_out_tlast(m_axis_tlast),
        .i_out_tvalid(m_axis_tvalid), .i_out_tready(m_axis_tready),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off when the sender asks for one.
    initial begin
        m_axis_tready = 1'b0;
        hold_given = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_given != hold_asked) begin
                hold_given++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("FAILED: results differ");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_item(logic [CMD_W-1:0] cmd,
                                                        logic [ADDR_W-1:0] addr,
                                                        logic [LEN_W-1:0] len,
                                                        logic [LINE_W-1:0] line,
                                                        logic [ARG_W-1:0] arg);
        return {3'b0, arg, line, len, addr, cmd};
    endfunction

    // Offer one item, idling first as the current mode says, and hold it until taken.
    task automatic send_item(logic [IN_TDATA_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tdata  <= data;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [PORT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Lines crowd into three sets so that fills evict.
    task automatic new_pool();
        logic [5:0] sets[3];
        for (int s = 0; s < 3; s++) sets[s] = $urandom_range(0, 63);
        for (int i = 0; i < POOL_N; i++)
            line_pool[i] = {28'($urandom()), sets[i % 3]};
        line_pool[0][LINE_W-1:6] = '1;
        line_pool[1][LINE_W-1:6] = '0;
    endtask

    function automatic logic [IN_TDATA_W-1:0] random_item();
        logic [LINE_W-1:0] line;
        logic [5:0]        off;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        logic [CMD_W-1:0]  cmd;
        logic [ARG_W-1:0]  arg;
        int r;
        r = $urandom_range(0, 99);
        line = line_pool[$urandom_range(0, POOL_N - 1)];
        if (r < 35) begin
            // core access, mostly aligned within the line
            cmd = $urandom_range(0, 3);
            if ($urandom_range(0, 9) < 9) begin
                len = $urandom_range(0, 8);
                off = $urandom_range(0, 64 - ((len == 0) ? 1 : len));
            end else begin
                len = $urandom_range(0, 64);
                off = $urandom();
            end
            addr = {line, off};
            if (cmd == CMD_LOAD_RES) last_lr_addr = addr;
            if (cmd == CMD_STORE_COND && $urandom_range(0, 9) < 7) addr = last_lr_addr;
            return pack_item(cmd, addr, len, 34'($urandom()), 8'($urandom()));
        end else if (r < 92) begin
            // bus message on a pool line with a plausible argument
            cmd = $urandom_range(CMD_INVALID, CMD_PUT_ACK);
            case (cmd)
                CMD_GETM_ACK:  arg = $urandom_range(0, 2);
                CMD_GETS_RESP: arg = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'(0);
                CMD_GETM_RESP: arg = $urandom_range(0, 1);
                default:       arg = $urandom();
            endcase
            return pack_item(cmd, 40'({$urandom(), $urandom()}), $urandom_range(0, 127),
                             line, arg);
        end
        // noise: anything the fields can hold
        return pack_item(4'($urandom()), 40'({$urandom(), $urandom()}),
                         $urandom_range(0, 127), 34'({$urandom(), $urandom()}),
                         8'($urandom()));
    endfunction

    // Hand-picked flows through the protocol, extremes and error cases.
    task automatic directed_part();
        logic [LINE_W-1:0] la;
        logic [LINE_W-1:0] lc;
        logic [LINE_W-1:0] top_line;
        la = 34'd5;
        lc = 34'h2_0000_0045;
        top_line = '1;
        send_item(pack_item(CMD_LOAD, {la, 6'd0}, 7'd0, '0, '0));
        send_item(pack_item(CMD_GETS_RESP, '0, '0, la, 8'd0));
        send_item(pack_item(CMD_STORE, {la, 6'd4}, 7'd4, '0, '0));
        send_item(pack_item(CMD_LOAD_RES, {la, 6'd8}, 7'd8, '0, '0));
        send_item(pack_item(CMD_STORE_COND, {la, 6'd8}, 7'd8, '0, '0));
        send_item(pack_item(CMD_STORE_COND, {la, 6'd16}, 7'd8, '0, '0));
        send_item(pack_item(CMD_GETS_FWD, '0, '0, la, 8'd255));
        send_item(pack_item(CMD_STORE, {la, 6'd0}, 7'd64, '0, '0));
        send_item(pack_item(CMD_GETM_ACK, '0, '0, la, 8'd1));
        send_item(pack_item(CMD_INV_ACK, '0, '0, la, 8'd0));
        send_item(pack_item(CMD_LOAD, '1, 7'd1, '0, '0));
        send_item(pack_item(CMD_LOAD, '1, 7'd2, '0, '0));
        send_item(pack_item(CMD_MEM_RESP, '0, '0, top_line, 8'd0));
        send_item(pack_item(CMD_STORE, {lc, 6'd63}, 7'd0, '0, '0));
        send_item(pack_item(CMD_GETM_RESP, '0, '0, lc, 8'd0));
        send_item(pack_item(CMD_GETM_ACK, '0, '0, lc, 8'd0));
        send_item(pack_item(CMD_INVALID, '0, '0, la, 8'd255));
        send_item(pack_item(CMD_PUT_ACK, '0, '0, la, 8'd0));
        send_item(pack_item(CMD_GETM_FWD, '0, '0, top_line, 8'd7));
        send_item(pack_item(CMD_GETS_FWD, '0, '0, 34'd99, 8'd0));
        send_item(pack_item(CMD_INV_ACK, '0, '0, 34'd99, 8'd0));
        send_item(pack_item(4'd15, '1, 7'd127, '1, 8'd255));
        send_item(pack_item(CMD_STORE_COND, '0, 7'd64, '0, '0));
    endtask

    initial begin
        logic [PORT_W-1:0] own_cfg[4];
        logic [PORT_W-1:0] up_cfg[4];
        own_cfg = '{8'd0, 8'd255, 8'hA5, 8'd0};
        up_cfg  = '{8'd255, 8'd0, 8'h3C, 8'd0};
        own_cfg[3] = $urandom();
        up_cfg[3]  = $urandom();
        i_rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tvalid = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_OWN_PORT;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_asked = 0;
        items_sent = 0;
        last_lr_addr = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(CFG_OWN_PORT, own_cfg[ph]);
            write_cfg(CFG_UPLINK_PORT, up_cfg[ph]);
            send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 16 : 0;
            recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 16 : 0;
            new_pool();
            if (ph == 0) directed_part();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 100) hold_asked++;
                if (ph == 2 && n == 200) begin
                    @(negedge i_clk);
                    s_axis_tvalid <= 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
                if (n % 40 == 0) send_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 16 :
                                                  ($urandom_range(0, 3) == 0) ? 30 : 0;
                send_item(random_item());
            end
            drain();
        end

        $display("run covered %0d input items and %0d results over four config and flow settings",
                 items_sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/mlc_pkg.sv
src/mlc_tag_ram.sv
src/mlc_engine.sv
src/mlc_res_fifo.sv
src/moesi_l1_coherence_controller.sv
verif/mlc_checker.sv
verif/tb_top.sv
